FILE: hw/rtl/source_lexer_assert.svh
// Assertion macros used by the checker file slx_checker.sv.
`ifndef SOURCE_LEXER_ASSERT_SVH
`define SOURCE_LEXER_ASSERT_SVH

// Property a |-> b, checked outside reset.
`define SLX_ASSERT_IMP(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Property a |=> b, checked outside reset.
`define SLX_ASSERT_NXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

FILE: hw/rtl/slx_pkg.sv
package slx_pkg;

    localparam int KwMaxLen = 8;
    localparam int KwIdxW = $clog2(KwMaxLen);

    localparam logic [5:0] K_IDENT  = 6'd18;
    localparam logic [5:0] K_NUMBER = 6'd19;
    localparam logic [5:0] K_STRING = 6'd20;
    localparam logic [5:0] K_EOF    = 6'd21;
    localparam logic [5:0] K_ERROR  = 6'd22;
    localparam logic [5:0] K_LPAREN = 6'd23;
    localparam logic [5:0] K_RPAREN = 6'd24;
    localparam logic [5:0] K_LBRACE = 6'd25;
    localparam logic [5:0] K_RBRACE = 6'd26;
    localparam logic [5:0] K_SEMI   = 6'd27;
    localparam logic [5:0] K_COMMA  = 6'd28;
    localparam logic [5:0] K_DOT    = 6'd29;
    localparam logic [5:0] K_NONE   = 6'd63;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_CHAR   = 2'd1;
    localparam logic [1:0] ERR_STRING = 2'd2;

    localparam logic [31:0] OFF_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [8:0] {
        M_IDLE     = 9'b000000001,
        M_COMMENT  = 9'b000000010,
        M_WORD     = 9'b000000100,
        M_NUMBER   = 9'b000001000,
        M_NUMDOT   = 9'b000010000,
        M_FRACTION = 9'b000100000,
        M_STRING   = 9'b001000000,
        M_OP       = 9'b010000000,
        M_DONE     = 9'b100000000
    } mode_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [1:0]  error_kind;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } token_t;

    typedef logic [7:0] kw_text_t [KwMaxLen];

    function automatic logic [15:0] inc16(input logic [15:0] v);
        inc16 = (v != CNT_MAX) ? v + 16'd1 : v;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= "0" && c <= "9";
    endfunction

    // Kind of a lone operator character, K_NONE if it is not one.
    function automatic logic [5:0] op_single(input logic [7:0] c);
        case (c)
            "-": op_single = 6'd30;
            "+": op_single = 6'd33;
            "/": op_single = 6'd36;
            "*": op_single = 6'd38;
            "%": op_single = 6'd40;
            "!": op_single = 6'd42;
            "=": op_single = 6'd44;
            "<": op_single = 6'd46;
            ">": op_single = 6'd48;
            default: op_single = K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] op_pair(input logic [7:0] a, input logic [7:0] b);
        if (a == "-" && b == "-")
            op_pair = 6'd31;
        else if (a == "-" && b == "=")
            op_pair = 6'd32;
        else if (a == "+" && b == "+")
            op_pair = 6'd34;
        else if (a == "+" && b == "=")
            op_pair = 6'd35;
        else if (a != "-" && a != "+" && b == "=" && op_single(a) != K_NONE)
            op_pair = op_single(a) + 6'd1;
        else
            op_pair = K_NONE;
    endfunction

    // Keyword lookup on the buffered word.
    function automatic logic [5:0] word_kind(input kw_text_t w, input logic [15:0] len);
        logic [5:0] k;
        k = K_IDENT;
        case (len)
            16'd2: begin
                if (w[0] == "i" && w[1] == "f") k = 6'd6;
                if (w[0] == "o" && w[1] == "r") k = 6'd8;
            end
            16'd3: begin
                if (w[0] == "a" && w[1] == "n" && w[2] == "d") k = 6'd0;
                if (w[0] == "f" && w[1] == "o" && w[2] == "r") k = 6'd4;
                if (w[0] == "v" && w[1] == "a" && w[2] == "r") k = 6'd16;
            end
            16'd4: begin
                if ({w[0], w[1], w[2], w[3]} == "else") k = 6'd2;
                if ({w[0], w[1], w[2], w[3]} == "null") k = 6'd7;
                if ({w[0], w[1], w[2], w[3]} == "puts") k = 6'd10;
                if ({w[0], w[1], w[2], w[3]} == "this") k = 6'd13;
                if ({w[0], w[1], w[2], w[3]} == "true") k = 6'd14;
            end
            16'd5: begin
                if ({w[0], w[1], w[2], w[3], w[4]} == "class") k = 6'd1;
                if ({w[0], w[1], w[2], w[3], w[4]} == "false") k = 6'd3;
                if ({w[0], w[1], w[2], w[3], w[4]} == "print") k = 6'd9;
                if ({w[0], w[1], w[2], w[3], w[4]} == "super") k = 6'd12;
                if ({w[0], w[1], w[2], w[3], w[4]} == "while") k = 6'd17;
            end
            16'd6: begin
                if ({w[0], w[1], w[2], w[3], w[4], w[5]} == "return") k = 6'd11;
                if ({w[0], w[1], w[2], w[3], w[4], w[5]} == "unless") k = 6'd15;
            end
            16'd8: begin
                if ({w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]} == "function")
                    k = 6'd5;
            end
            default: k = K_IDENT;
        endcase
        word_kind = k;
    endfunction

endpackage

FILE: hw/rtl/slx_if.sv
interface slx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_source;
    modport source (output valid, output char_byte, output end_of_source, input ready);
    modport sink (input valid, input char_byte, input end_of_source, output ready);
endinterface

interface slx_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [1:0]  error_kind;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
    modport source (output valid, output token_kind, output error_kind, output start_offset,
                    output token_length, output line_number, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input error_kind, input start_offset,
                  input token_length, input line_number, input last_of_run, output ready);
endinterface

FILE: hw/rtl/slx_front.sv
// Scanner: takes one byte per beat and produces up to three tokens at once.
module slx_front
    import slx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       grp_valid,
    input  logic       grp_ready,
    output logic [1:0] grp_count,
    output token_t     grp_tok [3]
);

    mode_t       mode_reg, mode_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] tstart_reg, tstart_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] wlen_reg, wlen_next;
    logic [7:0]  pend_reg, pend_next;
    kw_text_t    word_reg;
    logic        wr_en;
    logic [KwIdxW-1:0] wr_idx;

    token_t      tok [3];
    logic [1:0]  cnt;
    logic        fire;

    assign in_ready = grp_ready;
    assign fire = in_valid && in_ready;

    always_comb
    begin
        token_t t;
        logic used;
        logic [7:0] c;
        logic [5:0] k;
        c = in_byte;
        mode_next = mode_reg;
        offset_next = offset_reg;
        tstart_next = tstart_reg;
        line_next = line_reg;
        wlen_next = wlen_reg;
        pend_next = pend_reg;
        wr_en = 1'b0;
        wr_idx = '0;
        cnt = 2'd0;
        used = 1'b0;
        k = K_NONE;
        for (int i = 0; i < 3; i++)
        begin
            tok[i] = '0;
        end
        t = '0;
        if (in_end)
        begin
            // Pending token first, then EOF.
            t.error_kind = ERR_NONE;
            t.start_offset = tstart_reg;
            t.token_length = wlen_reg;
            case (mode_reg)
                M_WORD:
                begin
                    t.token_kind = word_kind(word_reg, wlen_reg);
                    tok[0] = t;
                    cnt = 2'd1;
                end
                M_NUMBER, M_FRACTION:
                begin
                    t.token_kind = K_NUMBER;
                    tok[0] = t;
                    cnt = 2'd1;
                end
                M_NUMDOT:
                begin
                    t.token_kind = K_NUMBER;
                    tok[0] = t;
                    t.token_kind = K_DOT;
                    t.start_offset = (offset_reg == '0) ? '0 : offset_reg - 32'd1;
                    t.token_length = 16'd1;
                    tok[1] = t;
                    cnt = 2'd2;
                end
                M_STRING:
                begin
                    t.token_kind = K_ERROR;
                    t.error_kind = ERR_STRING;
                    tok[0] = t;
                    cnt = 2'd1;
                end
                M_OP:
                begin
                    t.token_kind = op_single(pend_reg);
                    t.token_length = 16'd1;
                    tok[0] = t;
                    cnt = 2'd1;
                end
                default: cnt = 2'd0;
            endcase
            t = '0;
            t.token_kind = K_EOF;
            t.start_offset = offset_reg;
            tok[cnt] = t;
            cnt = cnt + 2'd1;
            mode_next = M_DONE;
        end
        else if (mode_reg == M_DONE)
        begin
            t.token_kind = K_EOF;
            t.start_offset = offset_reg;
            tok[0] = t;
            cnt = 2'd1;
        end
        else
        begin
            case (mode_reg)
                M_WORD:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (wlen_reg < 16'(KwMaxLen))
                        begin
                            wr_en = 1'b1;
                            wr_idx = wlen_reg[KwIdxW-1:0];
                        end
                        wlen_next = inc16(wlen_reg);
                        used = 1'b1;
                    end
                    else
                    begin
                        t.token_kind = word_kind(word_reg, wlen_reg);
                        t.start_offset = tstart_reg;
                        t.token_length = wlen_reg;
                        tok[0] = t;
                        cnt = 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_NUMBER, M_FRACTION:
                begin
                    if (is_digit(c))
                    begin
                        wlen_next = inc16(wlen_reg);
                        used = 1'b1;
                    end
                    else if (c == "." && mode_reg == M_NUMBER)
                    begin
                        mode_next = M_NUMDOT;
                        used = 1'b1;
                    end
                    else
                    begin
                        t.token_kind = K_NUMBER;
                        t.start_offset = tstart_reg;
                        t.token_length = wlen_reg;
                        tok[0] = t;
                        cnt = 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_NUMDOT:
                begin
                    if (is_digit(c))
                    begin
                        wlen_next = inc16(inc16(wlen_reg));
                        mode_next = M_FRACTION;
                        used = 1'b1;
                    end
                    else
                    begin
                        t.token_kind = K_NUMBER;
                        t.start_offset = tstart_reg;
                        t.token_length = wlen_reg;
                        tok[0] = t;
                        t.token_kind = K_DOT;
                        t.start_offset = (offset_reg == OFF_MAX) ? OFF_MAX
                                                                 : offset_reg - 32'd1;
                        t.token_length = 16'd1;
                        tok[1] = t;
                        cnt = 2'd2;
                        mode_next = M_IDLE;
                    end
                end
                M_STRING:
                begin
                    wlen_next = inc16(wlen_reg);
                    if (c == "\"")
                    begin
                        t.token_kind = K_STRING;
                        t.start_offset = tstart_reg;
                        t.token_length = wlen_next;
                        tok[0] = t;
                        cnt = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (c == "\n")
                    begin
                        line_next = inc16(line_reg);
                    end
                    used = 1'b1;
                end
                M_COMMENT:
                begin
                    if (c == "\n")
                        mode_next = M_IDLE;
                    else
                        used = 1'b1;
                end
                M_OP:
                begin
                    k = op_pair(pend_reg, c);
                    t.start_offset = tstart_reg;
                    if (k != K_NONE)
                    begin
                        t.token_kind = k;
                        t.token_length = 16'd2;
                        used = 1'b1;
                    end
                    else
                    begin
                        t.token_kind = op_single(pend_reg);
                        t.token_length = 16'd1;
                    end
                    tok[0] = t;
                    cnt = 2'd1;
                    mode_next = M_IDLE;
                end
                default: mode_next = M_IDLE;
            endcase
            if (!used)
            begin
                t = '0;
                t.start_offset = offset_reg;
                t.token_length = 16'd1;
                t.token_kind = K_NONE;
                case (c)
                    " ", "\r", "\t": t.token_kind = K_NONE;
                    "\n": line_next = inc16(line_reg);
                    "#": mode_next = M_COMMENT;
                    "\"":
                    begin
                        mode_next = M_STRING;
                        tstart_next = offset_reg;
                        wlen_next = 16'd1;
                    end
                    "(": t.token_kind = K_LPAREN;
                    ")": t.token_kind = K_RPAREN;
                    "{": t.token_kind = K_LBRACE;
                    "}": t.token_kind = K_RBRACE;
                    ";": t.token_kind = K_SEMI;
                    ",": t.token_kind = K_COMMA;
                    ".": t.token_kind = K_DOT;
                    default:
                    begin
                        if (is_alpha(c))
                        begin
                            mode_next = M_WORD;
                            tstart_next = offset_reg;
                            wlen_next = 16'd1;
                            wr_en = 1'b1;
                            wr_idx = '0;
                        end
                        else if (is_digit(c))
                        begin
                            mode_next = M_NUMBER;
                            tstart_next = offset_reg;
                            wlen_next = 16'd1;
                        end
                        else if (op_single(c) != K_NONE)
                        begin
                            mode_next = M_OP;
                            tstart_next = offset_reg;
                            wlen_next = 16'd1;
                            pend_next = c;
                        end
                        else
                        begin
                            t.token_kind = K_ERROR;
                            t.error_kind = ERR_CHAR;
                        end
                    end
                endcase
                if (t.token_kind != K_NONE)
                begin
                    tok[cnt] = t;
                    cnt = cnt + 2'd1;
                end
            end
            if (offset_reg != OFF_MAX)
                offset_next = offset_reg + 32'd1;
        end
        // A newline never produces a token after it in the same beat, so every
        // token carries the line count from before this byte; mark the last token.
        for (int i = 0; i < 3; i++)
        begin
            tok[i].line_number = line_reg;
            tok[i].last_of_run = (2'(i) == cnt - 2'd1);
        end
    end

    assign grp_valid = fire && (cnt != 2'd0);
    assign grp_count = cnt;
    assign grp_tok = tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            offset_reg <= '0;
            tstart_reg <= '0;
            line_reg <= 16'd1;
            wlen_reg <= '0;
            pend_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            offset_reg <= offset_next;
            tstart_reg <= tstart_next;
            line_reg <= line_next;
            wlen_reg <= wlen_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
            word_reg[wr_idx] <= in_byte;
    end

endmodule

FILE: hw/rtl/slx_queue.sv
// Token queue: takes a group of up to three tokens in one beat and hands them
// out one per beat. Ready upstream means room for a full group.
module slx_queue
    import slx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       grp_valid,
    output logic       grp_ready,
    input  logic [1:0] grp_count,
    input  token_t     grp_tok [3],
    output logic       out_valid,
    input  logic       out_ready,
    output token_t     out_tok
);

    localparam int Depth = 8;
    localparam int PtrW = $clog2(Depth);

    token_t          mem [Depth];
    logic [PtrW-1:0] wptr_reg, rptr_reg;
    logic [PtrW:0]   fill_reg, fill_next;
    logic            pop;
    logic [PtrW:0]   push_n;

    assign pop = out_valid && out_ready;
    assign push_n = grp_valid ? (PtrW+1)'(grp_count) : '0;
    assign grp_ready = fill_reg <= (PtrW+1)'(Depth - 3);
    assign out_valid = fill_reg != '0;
    assign out_tok = mem[rptr_reg];
    assign fill_next = fill_reg + push_n - (PtrW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + push_n[PtrW-1:0];
            if (pop)
                rptr_reg <= rptr_reg + PtrW'(1);
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (grp_valid && 2'(i) < grp_count)
                mem[wptr_reg + PtrW'(i)] <= grp_tok[i];
        end
    end

endmodule

FILE: hw/rtl/source_lexer.sv
// Streaming lexer.
// Channel in carries one source byte per beat (char_byte) or, with
// end_of_source set, the end of the text. Channel out carries one token per
// beat: kind, error kind, start offset, length, line number and a flag on the
// last token caused by an input beat.
// Each input beat is scanned in the cycle it is accepted; its tokens (zero to
// three) enter an eight-entry token queue and can leave from the next cycle.
// Throughput is one byte per cycle while the output keeps up; the output side
// gives one token per cycle while the receiver is ready, so a byte that ends
// three tokens holds up input only once the queue fills.
// in.ready is high while the queue has room for three tokens. When the
// receiver stalls, tokens wait in the queue and input stops once it is nearly
// full; nothing is dropped.
// Reset clears the scanner to its start (offset 0, line 1) and empties the
// queue. After the end beat every further beat yields one EOF token.
module source_lexer
    import slx_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    slx_byte_if.sink    in,
    slx_token_if.source out
);

    logic       grp_valid;
    logic       grp_ready;
    logic [1:0] grp_count;
    token_t     grp_tok [3];
    token_t     head;

    slx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .in_byte   (in.char_byte),
        .in_end    (in.end_of_source),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp_count (grp_count),
        .grp_tok   (grp_tok)
    );

    slx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp_count (grp_count),
        .grp_tok   (grp_tok),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .out_tok   (head)
    );

    assign out.token_kind   = head.token_kind;
    assign out.error_kind   = head.error_kind;
    assign out.start_offset = head.start_offset;
    assign out.token_length = head.token_length;
    assign out.line_number  = head.line_number;
    assign out.last_of_run  = head.last_of_run;

endmodule

FILE: hw/rtl/slx_checker.sv
`include "source_lexer_assert.svh"

module slx_checker
    import slx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  token_kind,
    input logic [1:0]  error_kind,
    input logic [15:0] token_length,
    input logic [15:0] line_number
);

    `SLX_ASSERT_IMP(a_err_kind, out_valid && token_kind != K_ERROR, error_kind == ERR_NONE,
        "error kind set on a token that is not an error")
    `SLX_ASSERT_IMP(a_eof_len, out_valid && token_kind == K_EOF, token_length == 16'd0,
        "EOF token with nonzero length")
    `SLX_ASSERT_IMP(a_line_pos, out_valid, line_number != 16'd0,
        "line number zero")
    `SLX_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(token_kind),
        "token dropped or changed while stalled")

endmodule

bind source_lexer slx_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out.valid),
    .out_ready    (out.ready),
    .token_kind   (out.token_kind),
    .error_kind   (out.error_kind),
    .token_length (out.token_length),
    .line_number  (out.line_number)
);

FILE: sim/source_lexer_checker.sv
`timescale 1ns / 1ps

module source_lexer_checker
    import slx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    slx_byte_if         in,
    slx_token_if        out,
    output int          failures,
    output int          tokens_pending
);

    typedef enum int {
        LX_IDLE, LX_COMMENT, LX_WORD, LX_NUMBER, LX_NUMDOT, LX_FRACTION, LX_STRING, LX_OP, LX_DONE
    } lex_state_e;

    lex_state_e  state;
    logic [31:0] offset;
    logic [31:0] tok_start;
    logic [15:0] line;
    logic [7:0]  word_text [8];
    logic [15:0] word_len;
    logic [7:0]  op_char;
    token_t      expected_tokens [$];
    token_t      run_tokens [$];

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [5:0] single_op(input logic [7:0] c);
        case (c)
            "-": return 6'd30;
            "+": return 6'd33;
            "/": return 6'd36;
            "*": return 6'd38;
            "%": return 6'd40;
            "!": return 6'd42;
            "=": return 6'd44;
            "<": return 6'd46;
            ">": return 6'd48;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] keyword_of(input int len);
        string w;
        string names [18];
        names = '{"and", "class", "else", "false", "for", "function", "if", "null", "or",
                  "print", "puts", "return", "super", "this", "true", "unless", "var",
                  "while"};
        if (len > 8)
            return K_IDENT;
        w = "";
        for (int i = 0; i < len; i++)
            w = {w, string'(word_text[i])};
        for (int k = 0; k < 18; k++)
            if (names[k] == w)
                return k[5:0];
        return K_IDENT;
    endfunction

    task automatic emit(input logic [5:0] kind, input logic [1:0] err,
                        input logic [31:0] start, input logic [15:0] len);
        token_t t;
        if (run_tokens.size() >= 3)
            return;
        t.token_kind = kind;
        t.error_kind = err;
        t.start_offset = start;
        t.token_length = len;
        t.line_number = line;
        t.last_of_run = 1'b0;
        run_tokens.push_back(t);
    endtask

    task automatic open_token(input lex_state_e s);
        state = s;
        tok_start = offset;
        word_len = 16'd1;
    endtask

    task automatic scan_idle(input logic [7:0] c);
        case (c)
            " ", "\r", "\t": ;
            "\n": line = sat_inc(line);
            "#": state = LX_COMMENT;
            8'h22: open_token(LX_STRING);
            "(": emit(K_LPAREN, ERR_NONE, offset, 16'd1);
            ")": emit(K_RPAREN, ERR_NONE, offset, 16'd1);
            "{": emit(K_LBRACE, ERR_NONE, offset, 16'd1);
            "}": emit(K_RBRACE, ERR_NONE, offset, 16'd1);
            ";": emit(K_SEMI, ERR_NONE, offset, 16'd1);
            ",": emit(K_COMMA, ERR_NONE, offset, 16'd1);
            ".": emit(K_DOT, ERR_NONE, offset, 16'd1);
            default:
            begin
                if (letter(c))
                begin
                    open_token(LX_WORD);
                    word_text[0] = c;
                end
                else if (digit(c))
                    open_token(LX_NUMBER);
                else if (single_op(c) != K_NONE)
                begin
                    open_token(LX_OP);
                    op_char = c;
                end
                else
                    emit(K_ERROR, ERR_CHAR, offset, 16'd1);
            end
        endcase
    endtask

    task automatic scan_byte(input logic [7:0] c);
        logic taken;
        logic [5:0] pair;
        taken = 1'b0;
        case (state)
            LX_WORD:
                if (letter(c) || digit(c))
                begin
                    if (word_len < 8)
                        word_text[word_len] = c;
                    word_len = sat_inc(word_len);
                    taken = 1'b1;
                end
                else
                begin
                    emit(keyword_of(word_len), ERR_NONE, tok_start, word_len);
                    state = LX_IDLE;
                end
            LX_NUMBER:
                if (digit(c))
                begin
                    word_len = sat_inc(word_len);
                    taken = 1'b1;
                end
                else if (c == ".")
                begin
                    state = LX_NUMDOT;
                    taken = 1'b1;
                end
                else
                begin
                    emit(K_NUMBER, ERR_NONE, tok_start, word_len);
                    state = LX_IDLE;
                end
            LX_NUMDOT:
                if (digit(c))
                begin
                    word_len = sat_inc(sat_inc(word_len));
                    state = LX_FRACTION;
                    taken = 1'b1;
                end
                else
                begin
                    emit(K_NUMBER, ERR_NONE, tok_start, word_len);
                    emit(K_DOT, ERR_NONE, (offset == OFF_MAX) ? OFF_MAX : offset - 1, 16'd1);
                    state = LX_IDLE;
                end
            LX_FRACTION:
                if (digit(c))
                begin
                    word_len = sat_inc(word_len);
                    taken = 1'b1;
                end
                else
                begin
                    emit(K_NUMBER, ERR_NONE, tok_start, word_len);
                    state = LX_IDLE;
                end
            LX_STRING:
            begin
                word_len = sat_inc(word_len);
                if (c == 8'h22)
                begin
                    emit(K_STRING, ERR_NONE, tok_start, word_len);
                    state = LX_IDLE;
                end
                else if (c == "\n")
                    line = sat_inc(line);
                taken = 1'b1;
            end
            LX_COMMENT:
                if (c == "\n")
                    state = LX_IDLE;
                else
                    taken = 1'b1;
            LX_OP:
            begin
                if (op_char == "-" && c == "-")
                    pair = 6'd31;
                else if (op_char == "-" && c == "=")
                    pair = 6'd32;
                else if (op_char == "+" && c == "+")
                    pair = 6'd34;
                else if (op_char == "+" && c == "=")
                    pair = 6'd35;
                else if (c == "=" && op_char != "-" && op_char != "+")
                    pair = single_op(op_char) + 6'd1;
                else
                    pair = K_NONE;
                if (pair != K_NONE)
                begin
                    emit(pair, ERR_NONE, tok_start, 16'd2);
                    taken = 1'b1;
                end
                else
                    emit(single_op(op_char), ERR_NONE, tok_start, 16'd1);
                state = LX_IDLE;
            end
            LX_DONE:
            begin
                emit(K_EOF, ERR_NONE, offset, 16'd0);
                return;
            end
            default: state = LX_IDLE;
        endcase
        if (!taken)
            scan_idle(c);
        if (offset != OFF_MAX)
            offset = offset + 1;
    endtask

    task automatic scan_end();
        case (state)
            LX_WORD: emit(keyword_of(word_len), ERR_NONE, tok_start, word_len);
            LX_NUMBER, LX_FRACTION: emit(K_NUMBER, ERR_NONE, tok_start, word_len);
            LX_NUMDOT:
            begin
                emit(K_NUMBER, ERR_NONE, tok_start, word_len);
                emit(K_DOT, ERR_NONE, (offset == 0) ? 32'd0 : offset - 1, 16'd1);
            end
            LX_STRING: emit(K_ERROR, ERR_STRING, tok_start, word_len);
            LX_OP: emit(single_op(op_char), ERR_NONE, tok_start, 16'd1);
            default: ;
        endcase
        emit(K_EOF, ERR_NONE, offset, 16'd0);
        state = LX_DONE;
    endtask

    assign tokens_pending = expected_tokens.size();

    always @(posedge clk or negedge rst_n)
    begin
        token_t got;
        token_t want;
        if (!rst_n)
        begin
            state = LX_IDLE;
            offset = '0;
            tok_start = '0;
            line = 16'd1;
            word_len = '0;
            op_char = '0;
            failures = 0;
            expected_tokens.delete();
        end
        else
        begin
            // The token beat is checked before this cycle's input beat adds tokens.
            if (out.valid && out.ready)
            begin
                got.token_kind = out.token_kind;
                got.error_kind = out.error_kind;
                got.start_offset = out.start_offset;
                got.token_length = out.token_length;
                got.line_number = out.line_number;
                got.last_of_run = out.last_of_run;
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token beat, kind %0d", got.token_kind);
                    failures++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got.token_kind != want.token_kind)
                    begin
                        $error("token_kind: expected %0d, got %0d",
                               want.token_kind, got.token_kind);
                        failures++;
                    end
                    if (got.error_kind != want.error_kind)
                    begin
                        $error("error_kind: expected %0d, got %0d",
                               want.error_kind, got.error_kind);
                        failures++;
                    end
                    if (got.start_offset != want.start_offset)
                    begin
                        $error("start_offset: expected %0d, got %0d",
                               want.start_offset, got.start_offset);
                        failures++;
                    end
                    if (got.token_length != want.token_length)
                    begin
                        $error("token_length: expected %0d, got %0d",
                               want.token_length, got.token_length);
                        failures++;
                    end
                    if (got.line_number != want.line_number)
                    begin
                        $error("line_number: expected %0d, got %0d",
                               want.line_number, got.line_number);
                        failures++;
                    end
                    if (got.last_of_run != want.last_of_run)
                    begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, got.last_of_run);
                        failures++;
                    end
                end
            end
            if (in.valid && in.ready)
            begin
                run_tokens.delete();
                if (in.end_of_source)
                    scan_end();
                else
                    scan_byte(in.char_byte);
                if (run_tokens.size() > 0)
                    run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
                foreach (run_tokens[i])
                    expected_tokens.push_back(run_tokens[i]);
            end
        end
    end

endmodule

FILE: sim/source_lexer_tb.sv
`timescale 1ns / 1ps

module source_lexer_tb;

    logic clk;
    logic rst_n;
    int   failures;
    int   tokens_pending;
    int   send_idle_pct;
    int   recv_stall_pct;

    slx_byte_if  in_ch ();
    slx_token_if out_ch ();

    source_lexer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    source_lexer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in             (in_ch),
        .out            (out_ch),
        .failures       (failures),
        .tokens_pending (tokens_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Drives one beat, with random idle cycles first, and waits for acceptance.
    // Valid stays high after the beat; an idle cycle or drain() drops it.
    task automatic send_beat(input logic [7:0] c, input logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.char_byte <= c;
        in_ch.end_of_source <= eos;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    function automatic string random_fragment();
        string kw [18];
        string ops [9];
        string s;
        string punct;
        string quote;
        string gap;
        string tail;
        int n;
        kw = '{"and", "class", "else", "false", "for", "function", "if", "null", "or",
               "print", "puts", "return", "super", "this", "true", "unless", "var", "while"};
        ops = '{"-", "+", "/", "*", "%", "!", "=", "<", ">"};
        punct = "(){};,.";
        quote = "\"";
        s = "";
        case ($urandom_range(9))
            0: s = kw[$urandom_range(17)];
            1:
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(97, 122)))};
            end
            2: s = $sformatf("%0d", $urandom_range(999));
            3: s = $sformatf("%0d.%0d", $urandom_range(99), $urandom_range(99));
            4: s = $sformatf("%0d.", $urandom_range(9));
            5:
            begin
                gap = $urandom_range(1) ? "\n" : " ";
                s = {quote, "ab", gap, quote};
            end
            6:
            begin
                tail = $urandom_range(1) ? "=" : ops[$urandom_range(8)];
                s = {ops[$urandom_range(8)], tail};
            end
            7: s = "# note\n";
            8: s = string'(punct[$urandom_range(6)]);
            default: s = string'(8'($urandom_range(255)));
        endcase
        gap = ($urandom_range(2) == 0) ? "\n" : " ";
        return {s, gap};
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tokens_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        string frag;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.char_byte = '0;
        in_ch.end_of_source = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: keywords, operators, dot after a number, comment, error bytes.
        send_text("while functions 12.5 7.x -= ++ a# c\n");
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h22, 1'b0);
        send_beat(8'h73, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'h41, 1'b0);
        drain();
        send_beat(8'h00, 1'b1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 25 : 51) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 25 : 51) : 0;
            for (int j = 0; j < 78; )
            begin
                frag = random_fragment();
                send_text(frag);
                j += frag.len();
            end
            if (phase == 1)
                drain();
        end
        send_beat(8'h4E, 1'b0);
        send_beat(8'h2E, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'h00, 1'b1);

        drain();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
